@@ sv/edtt_pkg.sv @@
// ----------------------------------------------------------------------------
// edtt_pkg
// Shared constants for the packed-decimal to ASCII text converter.
// ----------------------------------------------------------------------------
package edtt_pkg;

  // Layout of the packed input word.
  localparam int unsigned WordW     = 64;
  localparam int unsigned DigitW    = 54;
  localparam int unsigned PointLsb  = 55;
  localparam int unsigned CountLsb  = 59;
  localparam int unsigned SignBit   = 63;
  localparam int unsigned NibbleW   = 4;

  // 2^54 - 1 has 17 decimal digits.
  localparam int unsigned BcdDigits = 17;
  localparam int unsigned BcdW      = BcdDigits * 4;
  localparam int unsigned StepW     = 6;

  localparam int unsigned CharW     = 7;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharPoint = 7'h2E;
  localparam logic [CharW-1:0] CharNull  = 7'h00;

endpackage

@@ sv/encoded_decimal_to_text.sv @@
// ----------------------------------------------------------------------------
// encoded_decimal_to_text
// Renders one packed decimal word as ASCII text, one character per result.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low; the packed word
// on encoded_value_i is captured at that edge. The 54-bit digit value is then
// converted to BCD by a shift-and-add-3 unit that takes one bit per cycle.
// After that the characters follow one per cycle on char_code_o, each
// marked by a one-cycle result_valid_o pulse: an optional '-', then the
// zero-padded digits with '.' inserted, and the final digit carries
// last_char_o. The receiver cannot stall, so every strobed result must be
// taken in the cycle it is shown. A well-formed word passes through the
// conversion, then a step that checks the word and sends the '-' when
// there is one (so the sign adds no time), then the digits and the point.
// Busy falls as the last character is presented, so the next word can be
// started in that same cycle. A word whose point position exceeds its digit
// count, or whose digit value needs more digits than the count allows,
// produces one result with char_code 0, last_char 1 and malformed 1.
// ----------------------------------------------------------------------------
module encoded_decimal_to_text (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [edtt_pkg::WordW-1:0]  encoded_value_i,
  output logic                               result_valid_o,
  output logic [edtt_pkg::CharW-1:0]         char_code_o,
  output logic                               last_char_o,
  output logic                               malformed_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConvert,
    StDigits
  } state_e;

  state_e                          state_q;
  logic [edtt_pkg::NibbleW-1:0]    count_m1_q;  // digit count minus one
  logic [edtt_pkg::NibbleW-1:0]    point_m1_q;  // point position minus one
  logic                            negative_q;
  logic [edtt_pkg::NibbleW-1:0]    index_q;     // digit being emitted
  logic                            point_done_q;

  logic                            valid_q;
  logic [edtt_pkg::CharW-1:0]      char_q;
  logic                            last_q;
  logic                            bad_q;

  logic                            accept;
  logic                            conv_done;
  logic [edtt_pkg::BcdW-1:0]       bcd;
  logic                            overflow;
  logic                            bad_word;
  logic [3:0]                      cur_digit;

  assign accept = start && (state_q == StIdle);

  // The conversion unit sees the digit field directly.
  edtt_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (encoded_value_i[edtt_pkg::DigitW-1:0]),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  // The value does not fit when any BCD digit above the count is nonzero.
  always_comb begin
    overflow = 1'b0;
    for (int i = 0; i < edtt_pkg::BcdDigits; i++) begin
      if ((5'(i) > {1'b0, count_m1_q}) && (bcd[i*4 +: 4] != 4'd0)) begin
        overflow = 1'b1;
      end
    end
    bad_word  = overflow || (point_m1_q > count_m1_q);
    cur_digit = bcd[index_q*4 +: 4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_m1_q   <= '0;
      point_m1_q   <= '0;
      negative_q   <= 1'b0;
      index_q      <= '0;
      point_done_q <= 1'b0;
      valid_q      <= 1'b0;
      char_q       <= edtt_pkg::CharNull;
      last_q       <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            count_m1_q <= encoded_value_i[edtt_pkg::CountLsb +: edtt_pkg::NibbleW];
            point_m1_q <= encoded_value_i[edtt_pkg::PointLsb +: edtt_pkg::NibbleW];
            negative_q <= encoded_value_i[edtt_pkg::SignBit];
            state_q    <= StConvert;
          end
        end
        StConvert: begin
          if (conv_done) begin
            index_q      <= count_m1_q;
            point_done_q <= 1'b0;
            if (bad_word) begin
              // Single flagged result, then the transaction is over.
              valid_q <= 1'b1;
              char_q  <= edtt_pkg::CharNull;
              last_q  <= 1'b1;
              bad_q   <= 1'b1;
              state_q <= StIdle;
            end else begin
              if (negative_q) begin
                valid_q <= 1'b1;
                char_q  <= edtt_pkg::CharMinus;
                last_q  <= 1'b0;
                bad_q   <= 1'b0;
              end
              state_q <= StDigits;
            end
          end
        end
        StDigits: begin
          valid_q <= 1'b1;
          bad_q   <= 1'b0;
          if ((index_q == point_m1_q) && !point_done_q) begin
            // The point stands just left of the digit at point_m1.
            char_q       <= edtt_pkg::CharPoint;
            last_q       <= 1'b0;
            point_done_q <= 1'b1;
          end else begin
            char_q       <= edtt_pkg::CharZero + {3'b000, cur_digit};
            last_q       <= (index_q == '0);
            point_done_q <= 1'b0;
            if (index_q == '0) begin
              state_q <= StIdle;
            end else begin
              index_q <= index_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign char_code_o    = char_q;
  assign last_char_o    = last_q;
  assign malformed_o    = bad_q;

endmodule

@@ sv/edtt_dabble.sv @@
// ----------------------------------------------------------------------------
// edtt_dabble
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module edtt_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [edtt_pkg::DigitW-1:0]   value_i,
  output logic                          done_o,
  output logic [edtt_pkg::BcdW-1:0]     bcd_o
);

  localparam logic [edtt_pkg::StepW-1:0] LastStep =
    edtt_pkg::StepW'(edtt_pkg::DigitW - 1);

  logic                          run_q;
  logic                          done_q;
  logic [edtt_pkg::StepW-1:0]    step_q;
  logic [edtt_pkg::DigitW-1:0]   shift_q, shift_d;
  logic [edtt_pkg::BcdW-1:0]     bcd_q, bcd_d;
  logic [edtt_pkg::BcdW-1:0]     adj;

  // Every digit of 5 or more gets 3 added before the shift.
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < edtt_pkg::BcdDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end
    end
    bcd_d   = {adj[edtt_pkg::BcdW-2:0], shift_q[edtt_pkg::DigitW-1]};
    shift_d = {shift_q[edtt_pkg::DigitW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
      shift_q <= '0;
      bcd_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        step_q  <= '0;
        shift_q <= value_i;
        bcd_q   <= '0;
      end else if (run_q) begin
        shift_q <= shift_d;
        bcd_q   <= bcd_d;
        step_q  <= step_q + 1'b1;
        if (step_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ sv/edtt_checker.sv @@
// ----------------------------------------------------------------------------
// edtt_checker
// Port-level assertions for the packed-decimal to text converter.
// ----------------------------------------------------------------------------
module edtt_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               result_valid_o,
  input  logic [edtt_pkg::CharW-1:0]         char_code_o,
  input  logic                               last_char_o,
  input  logic                               malformed_o
);

  // A malformed word yields exactly one closing result with a null character.
  a_malformed_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && malformed_o) |->
      (last_char_o && (char_code_o == edtt_pkg::CharNull)))
    else $error("malformed result is not a single null character");

  // Only the closing character of a transaction may be shown while idle.
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !busy) |-> last_char_o)
    else $error("non-final character shown while not busy");

  // A new transaction needs a full conversion before its first character.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_char_o) |=> !result_valid_o)
    else $error("character directly after the final one");

  // An accepted transaction keeps the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a transaction was accepted");

  // Busy rises only in answer to start.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

endmodule

bind encoded_decimal_to_text edtt_checker u_edtt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .char_code_o     (char_code_o),
  .last_char_o     (last_char_o),
  .malformed_o     (malformed_o)
);

@@ tb/encoded_decimal_to_text_tb.sv @@
// ----------------------------------------------------------------------------
// encoded_decimal_to_text_tb
// Self-checking bench for the packed-decimal to ASCII text converter.
// ----------------------------------------------------------------------------
// A queue of packed words feeds a start/busy driver. A monitor on the rising
// edge records each accepted word, renders the text that the word should
// produce, and compares every strobed character against the oldest expected
// one. The stimulus has a short directed part and a longer random part. The
// random part is mostly well-formed words with random content, and the rest
// is words with the point beyond the digits, values too wide for the count,
// and raw random words.
// ----------------------------------------------------------------------------
module encoded_decimal_to_text_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One character of expected text, at the widths of the result ports.
  typedef struct packed {
    logic [edtt_pkg::CharW-1:0] code;
    logic                       last;
    logic                       bad;
  } text_char_t;

  // One word waiting to be sent. When drain is set, the driver holds the
  // word back until the block is idle and every character has arrived.
  // When steady is set, the driver sends the word without a random gap.
  typedef struct packed {
    logic [edtt_pkg::WordW-1:0] word;
    logic                       drain;
    logic                       steady;
  } word_item_t;

  localparam int unsigned RandomWords = 350;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned QuietLimit = 3000;
  localparam logic [edtt_pkg::WordW-1:0] DigitMax = 64'h003F_FFFF_FFFF_FFFF;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic signed [edtt_pkg::WordW-1:0]  encoded_value;
  logic                               result_valid;
  logic [edtt_pkg::CharW-1:0]         char_code;
  logic                               last_char;
  logic                               malformed;

  word_item_t word_feed[$];
  text_char_t expected_text[$];

  int unsigned words_total;
  int unsigned words_taken;
  int unsigned chars_seen;
  int unsigned bad_words;
  int unsigned neg_words;
  int unsigned error_count;
  int unsigned quiet_cycles;
  logic        word_taken;

  encoded_decimal_to_text u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .encoded_value_i (encoded_value),
    .result_valid_o  (result_valid),
    .char_code_o     (char_code),
    .last_char_o     (last_char),
    .malformed_o     (malformed)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // 10 to the given power; the largest needed is 10^16, well inside 64 bits.
  function automatic logic [edtt_pkg::WordW-1:0] ten_to(input int unsigned n);
    logic [edtt_pkg::WordW-1:0] acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < n; i++) acc = acc * 64'd10;
    return acc;
  endfunction

  // Packs a word from its fields. The spare bit just above the digit value
  // is carried along so that the block can be shown to ignore it.
  function automatic logic [edtt_pkg::WordW-1:0] pack_word(
    input logic                       neg,
    input int unsigned                count,
    input int unsigned                point,
    input logic [edtt_pkg::WordW-1:0] value,
    input logic                       spare);
    logic [edtt_pkg::WordW-1:0] w;
    w = '0;
    w[edtt_pkg::SignBit] = neg;
    w[edtt_pkg::CountLsb +: edtt_pkg::NibbleW] = edtt_pkg::NibbleW'(count - 1);
    w[edtt_pkg::PointLsb +: edtt_pkg::NibbleW] = edtt_pkg::NibbleW'(point - 1);
    w[edtt_pkg::DigitW] = spare;
    w[edtt_pkg::DigitW-1:0] = value[edtt_pkg::DigitW-1:0];
    return w;
  endfunction

  function automatic void queue_word(input logic [edtt_pkg::WordW-1:0] w,
                                     input logic drain, input logic steady);
    word_item_t item;
    item.word = w;
    item.drain = drain;
    item.steady = steady;
    word_feed.push_back(item);
  endfunction

  function automatic logic [edtt_pkg::WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Works out the text of one word and appends it to the expected characters.
  // Returns 1 when the word is malformed.
  function automatic logic render_word(input logic [edtt_pkg::WordW-1:0] w);
    logic [edtt_pkg::WordW-1:0] rest;
    int unsigned                count;
    int unsigned                point;
    logic [3:0]                 digit_of[16];
    text_char_t                 ch;
    count = int'(w[edtt_pkg::CountLsb +: edtt_pkg::NibbleW]) + 1;
    point = int'(w[edtt_pkg::PointLsb +: edtt_pkg::NibbleW]) + 1;
    rest = {{(edtt_pkg::WordW-edtt_pkg::DigitW){1'b0}}, w[edtt_pkg::DigitW-1:0]};
    // A point beyond the digits or a value too wide for the count collapses
    // the whole text to a single flagged null character.
    if (point > count || rest >= ten_to(count)) begin
      ch.code = edtt_pkg::CharNull;
      ch.last = 1'b1;
      ch.bad = 1'b1;
      expected_text.push_back(ch);
      return 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      digit_of[i] = 4'(rest % 64'd10);
      rest = rest / 64'd10;
    end
    ch.bad = 1'b0;
    ch.last = 1'b0;
    if (w[edtt_pkg::SignBit]) begin
      ch.code = edtt_pkg::CharMinus;
      expected_text.push_back(ch);
    end
    // Digits go out most significant first; the point goes in just before
    // the digit that has exactly "point" digits at and to its right.
    for (int i = int'(count) - 1; i >= 0; i--) begin
      if (i == int'(point) - 1) begin
        ch.code = edtt_pkg::CharPoint;
        ch.last = 1'b0;
        expected_text.push_back(ch);
      end
      ch.code = edtt_pkg::CharZero + {3'b000, digit_of[i]};
      ch.last = (i == 0);
      expected_text.push_back(ch);
    end
    return 1'b0;
  endfunction

  // Builds the whole stimulus: directed corner words first, then random ones.
  initial begin : build_stimulus
    int unsigned                count;
    int unsigned                point;
    int unsigned                width;
    int unsigned                pick;
    logic [edtt_pkg::WordW-1:0] value;
    logic                       drain;
    logic                       steady;

    // Directed corners.
    queue_word(64'h0, 1'b0, 1'b1);                                 // ".0"
    queue_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);               // all ones
    queue_word(pack_word(1'b1, 16, 1, ten_to(16) - 1, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 16, 16, ten_to(16) - 1, 1'b1), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 16, 1, ten_to(16), 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 16, 8, DigitMax, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 2, 2, 64'd5, 1'b0), 1'b0, 1'b1);     // "-.05"
    queue_word(pack_word(1'b0, 3, 1, 64'd999, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 3, 1, 64'd1000, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 3, 3, 64'd1000, 1'b1), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 1, 16, 64'd0, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 5, 6, 64'd12345, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 15, 16, 64'd1, 1'b1), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 1, 1, 64'd9, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 1, 1, 64'd10, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 16, 16, 64'd0, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 8, 4, 64'd31415926, 1'b1), 1'b0, 1'b1);
    queue_word(pack_word(1'b1, 10, 10, 64'd123, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 16, 2, 64'h0015_5555_5555_5555, 1'b0), 1'b0, 1'b1);
    queue_word(pack_word(1'b0, 12, 5, 64'h0000_00AA_AAAA_AAAA, 1'b1), 1'b0, 1'b1);

    // Random words. The first one waits for the directed text to drain, and
    // so does every ninetieth after it. A run of words in the middle goes
    // out with no random sender gaps, though one drain wait falls inside it.
    for (int unsigned n = 0; n < RandomWords; n++) begin
      drain = (n % 90 == 0);
      steady = (n >= 150 && n < 220);
      pick = $urandom_range(99);
      count = $urandom_range(16, 1);
      if (pick < 70) begin
        // Well-formed, with the magnitude spread over all widths.
        point = $urandom_range(count, 1);
        width = $urandom_range(count, 1);
        value = rand_word() % ten_to(width);
        if ($urandom_range(9) == 0) value = ten_to(count) - 1;
        queue_word(pack_word(1'($urandom_range(1)), count, point, value,
                             1'($urandom_range(1))),
                   drain, steady);
      end else if (pick < 80) begin
        if ($urandom_range(1) == 1 && count < 16) begin
          // Point beyond the digits.
          point = $urandom_range(16, count + 1);
          value = rand_word() % ten_to(count);
        end else begin
          // Value one or more past the largest that the count can hold.
          point = $urandom_range(count, 1);
          value = ten_to(count) + rand_word() % (DigitMax + 1 - ten_to(count));
        end
        queue_word(pack_word(1'($urandom_range(1)), count, point, value,
                             1'($urandom_range(1))),
                   drain, steady);
      end else begin
        queue_word(rand_word(), drain, steady);
      end
    end
    words_total = word_feed.size();
  end

  // Driver: changes the inputs on the falling edge. A word on the port stays
  // there until the monitor has seen it taken; only then is the next one
  // chosen, and start is left as it is while a word waits to be taken.
  always @(negedge clk_i) begin : drive_words
    logic       go;
    word_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      encoded_value <= '0;
    end else if (!(start && !word_taken)) begin
      go = 1'b0;
      if (word_feed.size() != 0) begin
        nxt = word_feed[0];
        go = 1'b1;
        if (nxt.drain && (expected_text.size() != 0 || busy)) begin
          go = 1'b0;
        end else if (!nxt.steady && $urandom_range(99) < 18) begin
          go = 1'b0;
        end
      end
      if (go) begin
        start <= 1'b1;
        encoded_value <= nxt.word;
        void'(word_feed.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: on the rising edge, takes in strobed characters and accepted
  // words. Results always belong to older words than the one being taken,
  // so checking before predicting keeps the expected order intact.
  always @(posedge clk_i) begin : watch_ports
    text_char_t want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (result_valid) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character code=%02h last=%0b malformed=%0b",
                   $time, char_code, last_char, malformed);
          error_count++;
        end else begin
          want = expected_text.pop_front();
          if (char_code !== want.code) begin
            $display("%0t: char_code expected %02h, got %02h", $time, want.code, char_code);
            error_count++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char expected %0b, got %0b", $time, want.last, last_char);
            error_count++;
          end
          if (malformed !== want.bad) begin
            $display("%0t: malformed expected %0b, got %0b", $time, want.bad, malformed);
            error_count++;
          end
        end
      end
      word_taken <= start && !busy;
      if (start && !busy) begin
        words_taken++;
        if (encoded_value[edtt_pkg::SignBit]) neg_words++;
        if (render_word(encoded_value)) bad_words++;
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count. The block
  // is silent mainly while it converts a word, plus sender gaps.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("encoded_decimal_to_text_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset, then wait for every word to be taken and every character to come
  // back, and allow one more full transaction time for stray results.
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (words_taken < words_total || expected_text.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Converted %0d words (%0d negative, %0d malformed) into %0d characters.",
             words_taken, neg_words, bad_words, chars_seen);
    $display("Mismatches found: %0d.", error_count);
    if (error_count == 0) begin
      $display("encoded_decimal_to_text_tb: done, clean");
    end else begin
      $display("encoded_decimal_to_text_tb: done, errors");
    end
    $finish;
  end

endmodule
